### design/t1_block_receive_check_unit_defines.svh
// Assertion macros for the T=1 block receive checker.
// Used by the top level; depends on nothing else.
`ifndef T1_BLOCK_RECEIVE_CHECK_UNIT_DEFINES_SVH
`define T1_BLOCK_RECEIVE_CHECK_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define T1BRC_ASSERT_SAME(lbl, ck, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define T1BRC_ASSERT_NEXT(lbl, ck, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/t1brc_pkg.sv
// Shared types and constants of the T=1 block receive checker.
// No dependencies; imported by every module of the block.
package t1brc_pkg;

	localparam int unsigned CHECK_BYTES = 1;
	localparam int unsigned HDR_BYTES   = 3;
	localparam int unsigned CNT_W       = 9;
	localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(HDR_BYTES + 255 + CHECK_BYTES);

	// Byte positions inside a block
	localparam logic [CNT_W-1:0] POS_NAD  = CNT_W'(0);
	localparam logic [CNT_W-1:0] POS_PCB  = CNT_W'(1);
	localparam logic [CNT_W-1:0] POS_LEN  = CNT_W'(2);
	localparam logic [CNT_W-1:0] POS_INFO = CNT_W'(3);

	// PCB classes and codes
	localparam logic [7:0] PCB_TYPE_MASK  = 8'hC0;
	localparam logic [7:0] PCB_TYPE_S     = 8'hC0;
	localparam logic [7:0] PCB_TYPE_R     = 8'h80;
	localparam logic [7:0] PCB_R_RSVD     = 8'h2C;
	localparam logic [7:0] PCB_RESYNC_REQ = 8'hC0;
	localparam logic [7:0] PCB_IFS_REQ    = 8'hC1;
	localparam logic [7:0] PCB_ABORT_REQ  = 8'hC2;
	localparam logic [7:0] PCB_WTX_REQ    = 8'hC3;
	localparam logic [7:0] PCB_RESYNC_RSP = 8'hE0;
	localparam logic [7:0] PCB_IFS_RSP    = 8'hE1;
	localparam logic [7:0] PCB_ABORT_RSP  = 8'hE2;
	localparam logic [7:0] PCB_WTX_RSP    = 8'hE3;

	localparam logic [7:0] LEN_MUTE = 8'hFF;
	localparam logic [7:0] IFS_MIN  = 8'h10;
	localparam logic [7:0] IFS_MAX  = 8'hFE;

	// Input transaction kinds
	localparam logic REQ_BYTE   = 1'b0;
	localparam logic REQ_RXFAIL = 1'b1;

	// Register map (word index)
	localparam logic REG_SENT_PCB    = 1'b0;
	localparam logic REG_FIRST_BLOCK = 1'b1;

	typedef enum logic [3:0] {
		ST_OK      = 4'd0,
		ST_PARITY  = 4'd1,
		ST_RXFAIL  = 4'd2,
		ST_MUTE    = 4'd3,
		ST_OTHER   = 4'd4,
		ST_LRC     = 4'd5,
		ST_NAD     = 4'd6,
		ST_BADLEN  = 4'd7,
		ST_IFSC    = 4'd8,
		ST_INVALID = 4'd9
	} status_t;

	// Per-block capture state
	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic [7:0]       lrc;
		logic [7:0]       nad;
		logic [7:0]       pcb;
		logic [7:0]       len;
		logic [7:0]       info;
		logic             parity;
	} blk_t;

endpackage

### design/t1brc_acc.sv
// Block accumulator: header capture, byte count and running XOR.
// Depends on t1brc_pkg.
module t1brc_acc import t1brc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic       req_type,
	input  logic [7:0] rx_byte,
	input  logic       parity_error,
	output blk_t       blk_cur,
	output blk_t       blk_nxt,
	output logic       blk_last
);

	blk_t blk_q;

	always_comb begin
		blk_nxt        = blk_q;
		blk_nxt.count  = blk_q.count + CNT_W'(1);
		blk_nxt.lrc    = blk_q.lrc ^ rx_byte;
		blk_nxt.parity = blk_q.parity | parity_error;
		case (blk_q.count)
			POS_NAD: blk_nxt.nad = rx_byte;
			POS_PCB: blk_nxt.pcb = rx_byte;
			POS_LEN: blk_nxt.len = rx_byte;
			POS_INFO: begin
				if (blk_q.len != 8'h00) begin
					blk_nxt.info = rx_byte;
				end
			end
			default: ;
		endcase
	end

	// Block ends when the count reaches header + LEN + check bytes
	assign blk_last = (blk_nxt.count >= CNT_W'(HDR_BYTES)) &&
		(blk_nxt.count == (CNT_W'(blk_nxt.len) + CNT_W'(HDR_BYTES + CHECK_BYTES)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blk_q <= '0;
		end else if (step) begin
			if (req_type == REQ_RXFAIL || blk_last) begin
				blk_q <= '0;
			end else begin
				blk_q <= blk_nxt;
			end
		end
	end

	assign blk_cur = blk_q;

endmodule

### design/t1brc_eval.sv
// Block status evaluation for a completed T=1 block.
// Depends on t1brc_pkg.
module t1brc_eval import t1brc_pkg::*; (
	input  blk_t       blk,
	input  logic [7:0] sent_pcb,
	input  logic       first_block,
	output status_t    status
);

	logic    sent_s;
	status_t s_status;

	assign sent_s = (sent_pcb & PCB_TYPE_MASK) == PCB_TYPE_S;

	always_comb begin
		case (blk.pcb)
			PCB_WTX_REQ: s_status = (blk.len != 8'd1) ? ST_BADLEN : ST_OK;
			PCB_IFS_REQ: begin
				if (blk.len != 8'd1) begin
					s_status = ST_BADLEN;
				end else if (blk.info < IFS_MIN || blk.info > IFS_MAX) begin
					s_status = ST_IFSC;
				end else begin
					s_status = ST_OK;
				end
			end
			PCB_RESYNC_REQ, PCB_ABORT_REQ: s_status = (blk.len != 8'd0) ? ST_OTHER : ST_OK;
			PCB_WTX_RSP, PCB_IFS_RSP: begin
				if (blk.len != 8'd1) begin
					s_status = ST_BADLEN;
				end else begin
					s_status = sent_s ? ST_OK : ST_INVALID;
				end
			end
			PCB_RESYNC_RSP, PCB_ABORT_RSP: begin
				if (blk.len != 8'd0) begin
					s_status = ST_BADLEN;
				end else begin
					s_status = sent_s ? ST_OK : ST_INVALID;
				end
			end
			default: s_status = ST_INVALID;
		endcase
	end

	// Priority: parity, NAD, mute, LRC, then block-type rules
	always_comb begin
		if (blk.parity) begin
			status = ST_PARITY;
		end else if (blk.nad != 8'h00) begin
			status = ST_NAD;
		end else if (blk.len == LEN_MUTE) begin
			status = (first_block && blk.pcb[7]) ? ST_OTHER : ST_MUTE;
		end else if (blk.lrc != 8'h00) begin
			status = ST_LRC;
		end else if ((blk.pcb & PCB_TYPE_MASK) == PCB_TYPE_S) begin
			status = s_status;
		end else if ((blk.pcb & PCB_TYPE_MASK) == PCB_TYPE_R) begin
			if (blk.len != 8'h00) begin
				status = ST_BADLEN;
			end else if ((blk.pcb & PCB_R_RSVD) != 8'h00) begin
				status = ST_INVALID;
			end else begin
				status = ST_OK;
			end
		end else begin
			status = ST_OK;
		end
	end

endmodule

### design/t1_block_receive_check_unit.sv
// T=1 block receive checker, top level: stream ports, APB registers, pipeline.
// Depends on t1brc_pkg, t1brc_acc, t1brc_eval and the assertion header.
//
// Usage:
//   Feed the bytes of a block received from the card on the s_ stream, one
//   transaction per byte (tdata = byte, tuser = kind and parity flag). A
//   receive failure (timeout and the like) is a transaction with the kind bit
//   set; its byte is ignored. One status transaction leaves on the m_ stream
//   when the last byte of a block (3 + LEN + 1) arrives or on a failure;
//   other bytes give no output.
//   A byte taken is evaluated in the input register and its status is
//   registered in the output register on m_tdata. Throughput: one byte per cycle
//   while no result is held back, with a single-pass check between the registers.
//   The input register keeps moving while a status waits, as long as it
//   holds no failure and no byte that ends a block; such a transaction waits
//   for the output register to drain, and s_tready drops behind it.
//   Reset clears the block state, both registers and the config registers
//   (sent_pcb = 0, first_block = 0). Write config only while idle.
//   Registers: 0x0 sent_pcb[7:0], 0x4 first_block[0].
module t1_block_receive_check_unit import t1brc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  logic [1:0]  s_tuser,   // [0] req_type, [1] parity_error
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [3:0] status, [11:4] block_pcb, [19:12] block_len,
	                               // [27:20] info_first, [36:28] bytes_received, [39:37] zero
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

`include "t1_block_receive_check_unit_defines.svh"

	// Config registers
	logic [7:0] sent_pcb_q;
	logic       first_block_q;
	logic       cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sent_pcb_q    <= '0;
			first_block_q <= 1'b0;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_SENT_PCB:    sent_pcb_q    <= pwdata[7:0];
				REG_FIRST_BLOCK: first_block_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_SENT_PCB:    prdata = {24'h0, sent_pcb_q};
			REG_FIRST_BLOCK: prdata = {31'h0, first_block_q};
			default:         prdata = '0;
		endcase
	end

	// Input register
	logic       valid_s1;
	logic       req_s1;
	logic [7:0] byte_s1;
	logic       perr_s1;
	logic       adv_s1;
	logic       emit_s1;

	// Output register
	logic             valid_s2;
	status_t          status_s2;
	logic [7:0]       pcb_s2;
	logic [7:0]       len_s2;
	logic [7:0]       info_s2;
	logic [CNT_W-1:0] count_s2;

	blk_t    blk_cur;
	blk_t    blk_nxt;
	logic    blk_last;
	status_t blk_status;

	// Advance unless this transaction makes a result and the output holds one that is not taken
	assign emit_s1  = (req_s1 == REQ_RXFAIL) || blk_last;
	assign adv_s1   = valid_s1 && (!emit_s1 || !valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			req_s1  <= s_tuser[0];
			perr_s1 <= s_tuser[1];
			byte_s1 <= s_tdata;
		end
	end

	t1brc_acc u_acc (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (adv_s1),
		.req_type     (req_s1),
		.rx_byte      (byte_s1),
		.parity_error (perr_s1),
		.blk_cur      (blk_cur),
		.blk_nxt      (blk_nxt),
		.blk_last     (blk_last)
	);

	t1brc_eval u_eval (
		.blk         (blk_nxt),
		.sent_pcb    (sent_pcb_q),
		.first_block (first_block_q),
		.status      (blk_status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1 && emit_s1) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	// A failure reports the state held so far; a block end reports it with the last byte
	always_ff @(posedge clk) begin
		if (adv_s1 && emit_s1) begin
			if (req_s1 == REQ_RXFAIL) begin
				status_s2 <= ST_RXFAIL;
				pcb_s2    <= blk_cur.pcb;
				len_s2    <= blk_cur.len;
				info_s2   <= blk_cur.info;
				count_s2  <= blk_cur.count;
			end else begin
				status_s2 <= blk_status;
				pcb_s2    <= blk_nxt.pcb;
				len_s2    <= blk_nxt.len;
				info_s2   <= blk_nxt.info;
				count_s2  <= blk_nxt.count;
			end
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {3'b000, count_s2, info_s2, len_s2, pcb_s2, status_s2};

	`T1BRC_ASSERT_SAME(a_count_bound, clk, arst_n, 1'b1, blk_cur.count <= MAX_COUNT,
		"block byte count beyond the longest block")
	`T1BRC_ASSERT_NEXT(a_clear_after_emit, clk, arst_n, adv_s1 && emit_s1,
		blk_cur.count == '0 && blk_cur.lrc == 8'h00 && m_tvalid,
		"block state not cleared or result missing after block end")
	`T1BRC_ASSERT_NEXT(a_rxfail_status, clk, arst_n, adv_s1 && req_s1 == REQ_RXFAIL,
		m_tdata[3:0] == ST_RXFAIL, "receive failure did not report rx fail")
	`T1BRC_ASSERT_SAME(a_stall_only_on_result, clk, arst_n, valid_s1 && !adv_s1,
		emit_s1 && valid_s2 && !m_tready, "input register stalled without a blocked result")

endmodule

### bench/tb.sv
// Self-checking testbench for the T=1 block receive checker (t1_block_receive_check_unit).
// Streams card bytes and receive failures and predicts every status transaction.
// Depends on t1brc_pkg and the RTL of the unit; reads no files.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import t1brc_pkg::*;

	// One expected or observed status transaction
	typedef struct {
		status_t          status;
		logic [7:0]       pcb;
		logic [7:0]       len;
		logic [7:0]       info;
		logic [CNT_W-1:0] nbytes;
	} blk_result_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // [7:0] rx_byte
	logic [1:0]  s_tuser;   // [0] req_type, [1] parity_error
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;   // [3:0] status, [11:4] block_pcb, [19:12] block_len,
	                        // [27:20] info_first, [36:28] bytes_received
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	// Shadow of the configuration registers
	logic [7:0] cfg_sent_pcb;
	logic       cfg_first_block;

	// Shadow of the per-block capture state
	logic [CNT_W-1:0] blk_cnt;
	logic [7:0]       blk_lrc;
	logic [7:0]       blk_nad;
	logic [7:0]       blk_pcb;
	logic [7:0]       blk_len;
	logic [7:0]       blk_info;
	logic             blk_par;

	blk_result_t pending_results[$];

	int mismatches;
	int items_sent;
	int send_idle_pct;
	int recv_stall_pct;
	int rx_hold_left;

	t1_block_receive_check_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop: far beyond the slowest legal run
	initial begin
		#5ms;
		$display("[t1_block_receive_check_unit] ERROR");
		$finish;
	end

	// ------------------------------------------------------------------
	// Status prediction
	// ------------------------------------------------------------------

	function automatic void clear_block_shadow();
		blk_cnt  = '0;
		blk_lrc  = '0;
		blk_nad  = '0;
		blk_pcb  = '0;
		blk_len  = '0;
		blk_info = '0;
		blk_par  = 1'b0;
	endfunction

	// Verdict on a completed block; checks run in priority order
	function automatic status_t judge_block();
		logic sent_s;
		sent_s = (cfg_sent_pcb & PCB_TYPE_MASK) == PCB_TYPE_S;
		if (blk_par)
			return ST_PARITY;
		if (blk_nad != 8'h00)
			return ST_NAD;
		// LEN 0xFF means the card went mute, unless the first exchange got a non-I block
		if (blk_len == LEN_MUTE)
			return (cfg_first_block && (blk_pcb & PCB_TYPE_R) != 8'h00) ? ST_OTHER : ST_MUTE;
		if (blk_lrc != 8'h00)
			return ST_LRC;
		if ((blk_pcb & PCB_TYPE_MASK) == PCB_TYPE_S) begin
			case (blk_pcb)
				PCB_WTX_REQ: begin
					return (blk_len != 8'd1) ? ST_BADLEN : ST_OK;
				end
				PCB_IFS_REQ: begin
					if (blk_len != 8'd1)
						return ST_BADLEN;
					if (blk_info < IFS_MIN || blk_info > IFS_MAX)
						return ST_IFSC;
					return ST_OK;
				end
				PCB_RESYNC_REQ, PCB_ABORT_REQ: begin
					return (blk_len != 8'd0) ? ST_OTHER : ST_OK;
				end
				PCB_WTX_RSP, PCB_IFS_RSP: begin
					if (blk_len != 8'd1)
						return ST_BADLEN;
					return sent_s ? ST_OK : ST_INVALID;
				end
				PCB_RESYNC_RSP, PCB_ABORT_RSP: begin
					if (blk_len != 8'd0)
						return ST_BADLEN;
					return sent_s ? ST_OK : ST_INVALID;
				end
				default: begin
					return ST_INVALID;
				end
			endcase
		end
		if ((blk_pcb & PCB_TYPE_MASK) == PCB_TYPE_R) begin
			if (blk_len != 8'd0)
				return ST_BADLEN;
			if ((blk_pcb & PCB_R_RSVD) != 8'h00)
				return ST_INVALID;
		end
		return ST_OK;
	endfunction

	function automatic void queue_status(status_t st);
		blk_result_t r;
		r.status = st;
		r.pcb    = blk_pcb;
		r.len    = blk_len;
		r.info   = blk_info;
		r.nbytes = blk_cnt;
		pending_results.push_back(r);
	endfunction

	// Advance the block shadow by one accepted transaction
	function automatic void track_rx_item(logic req, logic [7:0] b, logic perr);
		int unsigned total;
		if (req == REQ_RXFAIL) begin
			// a failure reports whatever was captured so far, parity notwithstanding
			queue_status(ST_RXFAIL);
			clear_block_shadow();
			return;
		end
		case (blk_cnt)
			POS_NAD: blk_nad = b;
			POS_PCB: blk_pcb = b;
			POS_LEN: blk_len = b;
			POS_INFO: begin
				if (blk_len != 8'd0)
					blk_info = b;
			end
			default: ;
		endcase
		blk_lrc = blk_lrc ^ b;
		if (perr)
			blk_par = 1'b1;
		blk_cnt = blk_cnt + 1'b1;
		total = HDR_BYTES + blk_len + CHECK_BYTES;
		if (blk_cnt >= HDR_BYTES && blk_cnt == CNT_W'(total)) begin
			queue_status(judge_block());
			clear_block_shadow();
		end
	endfunction

	// ------------------------------------------------------------------
	// Result side
	// ------------------------------------------------------------------

	function automatic void note_error(string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s", $realtime, msg);
	endfunction

	// Randomly stall the result stream; a pending hold-off forces a long stall
	initial begin
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold_left > 0) begin
				rx_hold_left = rx_hold_left - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	// Sample at the falling edge: the transaction completes at the next rising edge
	always @(negedge clk) begin
		blk_result_t got;
		blk_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.status = status_t'(m_tdata[3:0]);
			got.pcb    = m_tdata[11:4];
			got.len    = m_tdata[19:12];
			got.info   = m_tdata[27:20];
			got.nbytes = m_tdata[36:28];
			if (pending_results.size() == 0) begin
				note_error($sformatf("unexpected status transaction: status %0d pcb %h len %h",
					got.status, got.pcb, got.len));
			end else begin
				want = pending_results.pop_front();
				if (got.status !== want.status || got.pcb !== want.pcb ||
				    got.len !== want.len || got.info !== want.info ||
				    got.nbytes !== want.nbytes)
					note_error($sformatf({"status mismatch: exp st %0d pcb %h len %h info %h n %0d",
						" / got st %0d pcb %h len %h info %h n %0d"},
						want.status, want.pcb, want.len, want.info, want.nbytes,
						got.status, got.pcb, got.len, got.info, got.nbytes));
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// Offer one transaction, idling first at random; predict once it is taken
	task automatic send_item(logic req, logic [7:0] b, logic perr);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tuser  <= {perr, req};
		// check ready where it is settled, then complete on the rising edge
		do
			@(negedge clk);
		while (!s_tready);
		@(posedge clk);
		track_rx_item(req, b, perr);
		items_sent++;
	endtask

	// Send NAD, PCB, LEN, LEN info bytes and the LRC; optionally corrupt the
	// LRC, flag a parity error on one byte, or cut the block with a failure
	task automatic send_block(logic [7:0] nad, logic [7:0] pcb, logic [7:0] len,
		logic [7:0] info0, bit bad_lrc, int perr_at, int fail_at);
		logic [7:0] frame[$];
		logic [7:0] lrc;
		frame.push_back(nad);
		frame.push_back(pcb);
		frame.push_back(len);
		for (int i = 0; i < len; i++)
			frame.push_back(i == 0 ? info0 : 8'($urandom));
		lrc = 8'h00;
		foreach (frame[i])
			lrc = lrc ^ frame[i];
		if (bad_lrc)
			lrc = lrc ^ 8'($urandom_range(1, 255));
		frame.push_back(lrc);
		foreach (frame[i]) begin
			if (i == fail_at) begin
				send_item(REQ_RXFAIL, 8'($urandom), 1'($urandom));
				return;
			end
			send_item(REQ_BYTE, frame[i], i == perr_at);
		end
	endtask

	// Drop valid and wait for every predicted status, then let the pipeline settle
	task automatic wait_idle();
		int guard;
		s_tvalid <= 1'b0;
		guard = 0;
		while (pending_results.size() != 0 && guard < 100000) begin
			@(posedge clk);
			guard++;
		end
		repeat (4) @(posedge clk);
	endtask

	// Setup and access cycle; the register takes the value at the access edge
	task automatic write_reg(logic idx, logic [7:0] val);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= {idx, 2'b00};
		pwdata  <= {24'h0, val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (idx == REG_SENT_PCB)
			cfg_sent_pcb = val;
		else
			cfg_first_block = val[0];
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_config(logic [7:0] sent_pcb, logic first_block);
		write_reg(REG_SENT_PCB, sent_pcb);
		write_reg(REG_FIRST_BLOCK, {7'h0, first_block});
	endtask

	// Mostly well-formed blocks of every class with random content
	task automatic rand_block();
		int kind;
		int nbytes;
		int perr_at;
		int fail_at;
		logic [7:0] nad;
		logic [7:0] pcb;
		logic [7:0] len;
		logic [7:0] info0;
		bit bad;
		kind  = $urandom_range(0, 99);
		nad   = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
		info0 = 8'($urandom);
		if (kind < 30) begin
			pcb = 8'($urandom_range(0, 127));
			len = 8'($urandom_range(0, 6));
		end else if (kind < 45) begin
			pcb = PCB_TYPE_R | 8'($urandom_range(0, 63));
			if ($urandom_range(0, 1))
				pcb = pcb & ~PCB_R_RSVD;
			len = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(1, 3)) : 8'h00;
		end else if (kind < 85) begin
			case ($urandom_range(0, 8))
				0: pcb = PCB_RESYNC_REQ;
				1: pcb = PCB_IFS_REQ;
				2: pcb = PCB_ABORT_REQ;
				3: pcb = PCB_WTX_REQ;
				4: pcb = PCB_RESYNC_RSP;
				5: pcb = PCB_IFS_RSP;
				6: pcb = PCB_ABORT_RSP;
				7: pcb = PCB_WTX_RSP;
				default: pcb = PCB_TYPE_S | 8'($urandom_range(0, 63));
			endcase
			if (pcb == PCB_IFS_REQ || pcb == PCB_WTX_REQ || pcb == PCB_IFS_RSP ||
			    pcb == PCB_WTX_RSP)
				len = 8'd1;
			else
				len = 8'd0;
			if ($urandom_range(0, 4) == 0)
				len = 8'($urandom_range(0, 2));
			// hit the IFS window edges often
			if ($urandom_range(0, 1)) begin
				case ($urandom_range(0, 4))
					0: info0 = 8'h00;
					1: info0 = IFS_MIN - 8'd1;
					2: info0 = IFS_MIN;
					3: info0 = IFS_MAX;
					default: info0 = 8'hFF;
				endcase
			end
		end else if (kind < 99) begin
			pcb = 8'($urandom);
			len = 8'($urandom_range(0, 3));
		end else begin
			// rare long block, mute length included
			pcb = 8'($urandom);
			len = $urandom_range(0, 1) ? LEN_MUTE : 8'($urandom_range(7, 254));
		end
		bad     = ($urandom_range(0, 9) == 0);
		nbytes  = 4 + len;
		perr_at = ($urandom_range(0, 11) == 0) ? $urandom_range(0, nbytes - 1) : -1;
		fail_at = ($urandom_range(0, 19) == 0) ? $urandom_range(0, nbytes - 1) : -1;
		send_block(nad, pcb, len, info0, bad, perr_at, fail_at);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Short blocks covering the parity, NAD, LRC and R-block checks, plus failures with and without bytes
	task automatic test_basic_frames();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		send_item(REQ_RXFAIL, 8'hFF, 1'b1);                    // failure before any byte
		send_block(8'h00, 8'h00, 8'h00, 8'h00, 0, -1, -1);     // clean I-block
		send_block(8'h00, 8'h40, 8'h00, 8'h00, 0, 3, -1);      // parity on the LRC byte
		send_block(8'hFF, 8'h00, 8'h00, 8'h00, 0, -1, -1);     // bad NAD
		send_block(8'h00, 8'h7F, 8'h00, 8'h00, 1, -1, -1);     // bad LRC
		send_block(8'h00, 8'hAC, 8'h00, 8'h00, 0, -1, -1);     // R-block, reserved bits set
		send_block(8'h00, 8'h00, 8'h02, 8'h00, 0, 1, 2);       // failure after a parity error
		wait_idle();
	endtask

	// LEN 0xFF blocks during the first exchange: non-I gives other, I gives mute
	task automatic test_mute_length();
		set_config(8'hFF, 1'b1);
		send_block(8'h00, PCB_TYPE_R, LEN_MUTE, 8'h00, 0, -1, -1);
		send_block(8'h00, 8'h00, LEN_MUTE, 8'h00, 0, -1, -1);
		wait_idle();
	endtask

	// Hold the result stream off while blocks stream in, so the input stalls
	task automatic test_backpressure();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		rx_hold_left   = 300;
		repeat (12)
			send_block(8'h00, 8'h00, 8'h00, 8'h00, 0, -1, -1);
		wait_idle();
	endtask

	// Random blocks mixed with stray transactions under one idling profile
	task automatic test_random_traffic(int send_pct, int stall_pct, int n_items);
		int start;
		send_idle_pct  = send_pct;
		recv_stall_pct = stall_pct;
		start = items_sent;
		while (items_sent - start < n_items) begin
			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(1, 4))
					send_item(($urandom_range(0, 3) == 0) ? REQ_RXFAIL : REQ_BYTE,
						8'($urandom), 1'($urandom));
			end else begin
				rand_block();
			end
		end
		wait_idle();
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------

	initial begin
		// drive every input to a known value from time zero
		arst_n         <= 1'b0;
		s_tvalid       <= 1'b0;
		s_tdata        <= 8'h00;
		s_tuser        <= 2'b00;
		psel           <= 1'b0;
		penable        <= 1'b0;
		pwrite         <= 1'b0;
		paddr          <= 3'd0;
		pwdata         <= 32'h0;
		mismatches     = 0;
		items_sent     = 0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		rx_hold_left   = 0;
		cfg_sent_pcb   = 8'h00;
		cfg_first_block = 1'b0;
		clear_block_shadow();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic_frames();
		test_mute_length();
		test_backpressure();

		set_config(8'h00, 1'b0);
		test_random_traffic(0, 0, 190);
		set_config(8'hFF, 1'b1);
		test_random_traffic(87, 0, 190);
		set_config(8'($urandom_range(0, 8'hBF)), 1'b0);
		test_random_traffic(0, 87, 190);
		set_config(8'($urandom_range(8'hC0, 8'hFF)), 1'b1);
		test_random_traffic(14, 14, 190);

		if (pending_results.size() != 0)
			note_error($sformatf("%0d status transactions never arrived",
				pending_results.size()));
		if (mismatches == 0) begin
			$display("[t1_block_receive_check_unit] OK");
		end else begin
			$display("[t1_block_receive_check_unit] ERROR");
		end
		$finish;
	end

endmodule

### filelist.f
+incdir+design
design/t1brc_pkg.sv
design/t1brc_acc.sv
design/t1brc_eval.sv
design/t1_block_receive_check_unit.sv
bench/tb.sv
